>>> rtl/tsc_pkg.sv
// shared constants and types of the trajectory smoothing block
`timescale 1ns / 1ps
package tsc_pkg;

	// field widths
	localparam int SHIFT_W    = 24;
	localparam int ROT_W      = 20;
	localparam int OUT_W      = 32;
	localparam int PATH_W     = 40;

	// motion channels
	localparam int NUM_CH     = 3;
	localparam logic [1:0] CH_X   = 2'd0;
	localparam logic [1:0] CH_Y   = 2'd1;
	localparam logic [1:0] CH_ANG = 2'd2;

	// default smoothing radius in frames
	localparam int RADIUS_DEF = 30;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/tsc_if.sv
// handshake channels for motion items and correction items
`timescale 1ns / 1ps
interface tsc_motion_if;
	import tsc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SHIFT_W-1:0] shift_x;
	logic signed [SHIFT_W-1:0] shift_y;
	logic signed [ROT_W-1:0]   rotation;
	logic                      end_of_sequence;

	modport source (
		output valid, shift_x, shift_y, rotation, end_of_sequence,
		input  ready
	);
	modport sink (
		input  valid, shift_x, shift_y, rotation, end_of_sequence,
		output ready
	);
endinterface

interface tsc_corr_if;
	import tsc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] corrected_x;
	logic signed [OUT_W-1:0] corrected_y;
	logic signed [OUT_W-1:0] corrected_angle;
	logic                    final_result;

	modport source (
		output valid, corrected_x, corrected_y, corrected_angle, final_result,
		input  ready
	);
	modport sink (
		input  valid, corrected_x, corrected_y, corrected_angle, final_result,
		output ready
	);
endinterface

>>> rtl/tsc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tsc_div.sv
// serial restoring divider, signed dividend by unsigned divisor, truncating toward zero
`timescale 1ns / 1ps
module tsc_div #(
	parameter int DIVIDEND_W = 46,
	parameter int DIVISOR_W  = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [DIVIDEND_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]          divisor,
	output tsc_pkg::div_stat_t            stat,
	output logic signed [DIVIDEND_W-1:0]  quotient
);
	import tsc_pkg::*;

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [STEP_W-1:0]     step_q;
	logic                  neg_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	// one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIVIDEND_W);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// magnitude, partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIVIDEND_W-1];
			quo_q <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q && step_q != '0) begin
			rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	// sign restore on the way out
	assign quotient  = neg_q ? $signed(-quo_q) : $signed(quo_q);
	assign stat.busy = busy_q;
	assign stat.done = busy_q && step_q == '0;

endmodule

>>> rtl/trajectory_smoothing_correction.sv
// Trajectory smoothing correction: each motion item (shift_x, shift_y, rotation) is added
// into a saturating 40-bit trajectory whose last 2*RADIUS+1 points sit in a ring ram. Each
// correction item is the centred window mean of the trajectory (truncated toward zero,
// window shortened at the start and end of a sequence) minus the previous trajectory
// point, saturated to 32 bits; it leaves RADIUS items after its own frame, and the item
// marked end_of_sequence releases all pending corrections and restarts the sequence. One
// serial divider serves all three channels, one quotient bit per cycle, and sets the rate.
// An item that causes no correction passes the evict and insert steps; one that causes a
// correction goes on through the trim, previous-point, division and output steps, and the
// final item repeats these for each further released correction, with a trim subtraction
// per point dropped from the shrinking window. The block is not ready while an item
// is in progress; a finished correction waits in an output register without stalling the
// next item's intake, but a correction that cannot enter that register because the
// receiver has not taken the one before holds the sequencer in its output step. The ring
// holds no reset contents and needs no clearing pass.
`timescale 1ns / 1ps
module trajectory_smoothing_correction #(
	parameter int RADIUS = tsc_pkg::RADIUS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tsc_motion_if.sink        motion,
	tsc_corr_if.source        correction
);
	import tsc_pkg::*;

	localparam int RING  = 2 * RADIUS + 1;
	localparam int IDX_W = $clog2(RING);
	localparam int CNT_W = $clog2(RING + 1);
	localparam int SUM_W = PATH_W + $clog2(RING);
	localparam int MEM_W = NUM_CH * PATH_W;

	localparam logic [CNT_W-1:0] RING_C    = CNT_W'(RING);
	localparam logic [CNT_W-1:0] RAD_C     = CNT_W'(RADIUS);
	localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(RING - 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_EVICT    = 8'b0000_0010,
		S_INSERT   = 8'b0000_0100,
		S_TRIM     = 8'b0000_1000,
		S_TRIM_SUB = 8'b0001_0000,
		S_PREV     = 8'b0010_0000,
		S_DIV      = 8'b0100_0000,
		S_OUT      = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic signed [PATH_W-1:0] path_q [NUM_CH];
	logic signed [SUM_W-1:0]  sum_q  [NUM_CH];
	logic signed [PATH_W-1:0] prev_q [NUM_CH];
	logic [OUT_W-1:0]         corr_q [NUM_CH];
	logic [OUT_W-1:0]         out_corr_q [NUM_CH];
	logic                     out_final_q;
	logic                     out_valid_q;
	logic [IDX_W-1:0]         head_q;
	logic [CNT_W-1:0]         frames_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         k_q;
	logic [1:0]               ch_q;
	logic                     eos_q;

	logic signed [PATH_W-1:0] step_ext [NUM_CH];
	logic [CNT_W-1:0]         frames_nx;
	logic [CNT_W-1:0]         win_top;
	logic [CNT_W-1:0]         target;
	logic [CNT_W-1:0]         kp1;
	logic [CNT_W-1:0]         kend;
	logic                     trim_hit;
	logic                     prev_ok;
	logic                     out_free;
	logic                     accept;

	logic [IDX_W-1:0]         raddr;
	logic [MEM_W-1:0]         wdata;
	logic [MEM_W-1:0]         rdata;
	logic                     we;

	logic                     div_start;
	logic [1:0]               div_ch;
	div_stat_t                div_stat;
	logic signed [SUM_W-1:0]  div_quo;

	// saturating trajectory accumulate
	function automatic logic signed [PATH_W-1:0] sat_path(
		input logic signed [PATH_W-1:0] a,
		input logic signed [PATH_W-1:0] b
	);
		logic [PATH_W:0] s;
		s = {a[PATH_W-1], a} + {b[PATH_W-1], b};
		if (s[PATH_W] != s[PATH_W-1]) begin
			return s[PATH_W] ? {1'b1, {(PATH_W-1){1'b0}}} : {1'b0, {(PATH_W-1){1'b1}}};
		end
		return s[PATH_W-1:0];
	endfunction

	// clamp a wide difference to the output range
	function automatic logic [OUT_W-1:0] sat_out(input logic [SUM_W:0] d);
		if ((&d[SUM_W:OUT_W-1]) || !(|d[SUM_W:OUT_W-1])) begin
			return d[OUT_W-1:0];
		end
		return d[SUM_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
	endfunction

	// widen a trajectory point to sum width
	function automatic logic signed [SUM_W-1:0] ext_sum(input logic [PATH_W-1:0] p);
		return {{(SUM_W-PATH_W){p[PATH_W-1]}}, p};
	endfunction

	// ring slot of the point d places older than the newest
	function automatic logic [IDX_W-1:0] slot_back(
		input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] d
	);
		logic [IDX_W:0] s;
		s = {1'b0, head} + (IDX_W+1)'(RING - 1) - (IDX_W+1)'(d);
		if (s >= (IDX_W+1)'(RING)) begin
			s = s - (IDX_W+1)'(RING);
		end
		return s[IDX_W-1:0];
	endfunction

	// motion fields widened to trajectory width
	assign step_ext[CH_X]   = {{(PATH_W-SHIFT_W){motion.shift_x[SHIFT_W-1]}}, motion.shift_x};
	assign step_ext[CH_Y]   = {{(PATH_W-SHIFT_W){motion.shift_y[SHIFT_W-1]}}, motion.shift_y};
	assign step_ext[CH_ANG] = {{(PATH_W-ROT_W){motion.rotation[ROT_W-1]}}, motion.rotation};

	// window bookkeeping
	assign frames_nx = (frames_q == RING_C) ? frames_q : frames_q + 1'b1;
	assign win_top   = k_q + RAD_C + 1'b1;
	assign target    = (win_top > frames_q) ? frames_q : win_top;
	assign kp1       = k_q + 1'b1;
	assign kend      = eos_q ? '0 : RAD_C;
	assign trim_hit  = cnt_q > target;
	assign prev_ok   = kp1 < frames_q;
	assign out_free  = !out_valid_q || correction.ready;
	assign accept    = motion.valid && motion.ready;

	// ring read address
	always_comb begin
		raddr = head_q;
		if (state_q == S_TRIM) begin
			if (trim_hit) begin
				raddr = slot_back(head_q, cnt_q - 1'b1);
			end else if (prev_ok) begin
				raddr = slot_back(head_q, kp1);
			end
		end
	end

	// ring write of the new trajectory point
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			wdata[c*PATH_W +: PATH_W] = path_q[c];
		end
	end
	assign we = state_q == S_INSERT;

	tsc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (RING)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (head_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// shared divider, one channel after another
	assign div_ch    = (state_q == S_PREV) ? CH_X : ch_q + 1'b1;
	assign div_start = (state_q == S_PREV) ||
		(state_q == S_DIV && div_stat.done && ch_q != CH_ANG);

	tsc_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[div_ch]),
		.divisor  (cnt_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			frames_q    <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			ch_q        <= CH_X;
			eos_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				path_q[c] <= '0;
				sum_q[c]  <= '0;
			end
		end else begin
			// output register empties when taken, unless refilled below
			if (correction.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						eos_q <= motion.end_of_sequence;
						for (int c = 0; c < NUM_CH; c++) begin
							path_q[c] <= sat_path(path_q[c], step_ext[c]);
						end
						state_q <= S_EVICT;
					end
				end
				S_EVICT: begin
					// oldest point leaves a full ring
					if (frames_q == RING_C) begin
						for (int c = 0; c < NUM_CH; c++) begin
							sum_q[c] <= sum_q[c] - ext_sum(rdata[c*PATH_W +: PATH_W]);
						end
					end
					state_q <= S_INSERT;
				end
				S_INSERT: begin
					for (int c = 0; c < NUM_CH; c++) begin
						sum_q[c] <= sum_q[c] + ext_sum(path_q[c]);
					end
					head_q   <= (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
					frames_q <= frames_nx;
					cnt_q    <= frames_nx;
					k_q      <= (frames_nx > RAD_C) ? RAD_C : frames_nx - 1'b1;
					if (!eos_q && frames_nx <= RAD_C) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TRIM;
					end
				end
				S_TRIM: begin
					state_q <= trim_hit ? S_TRIM_SUB : S_PREV;
				end
				S_TRIM_SUB: begin
					// oldest point beyond the shrinking window
					for (int c = 0; c < NUM_CH; c++) begin
						sum_q[c] <= sum_q[c] - ext_sum(rdata[c*PATH_W +: PATH_W]);
					end
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_TRIM;
				end
				S_PREV: begin
					ch_q    <= CH_X;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (ch_q == CH_ANG) begin
							state_q <= S_OUT;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (k_q == kend) begin
							// end of sequence restarts the trajectory
							if (eos_q) begin
								head_q   <= '0;
								frames_q <= '0;
								for (int c = 0; c < NUM_CH; c++) begin
									path_q[c] <= '0;
									sum_q[c]  <= '0;
								end
							end
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q - 1'b1;
							state_q <= S_TRIM;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// previous point, corrections and output register
	always_ff @(posedge clk) begin
		if (state_q == S_PREV) begin
			for (int c = 0; c < NUM_CH; c++) begin
				prev_q[c] <= prev_ok ? rdata[c*PATH_W +: PATH_W] : '0;
			end
		end
		if (state_q == S_DIV && div_stat.done) begin
			corr_q[ch_q] <= sat_out({div_quo[SUM_W-1], div_quo} -
				{{(SUM_W+1-PATH_W){prev_q[ch_q][PATH_W-1]}}, prev_q[ch_q]});
		end
		if (state_q == S_OUT && out_free) begin
			for (int c = 0; c < NUM_CH; c++) begin
				out_corr_q[c] <= corr_q[c];
			end
			out_final_q <= eos_q && k_q == '0;
		end
	end

	// port drive
	assign motion.ready               = state_q == S_IDLE;
	assign correction.valid           = out_valid_q;
	assign correction.corrected_x     = out_corr_q[CH_X];
	assign correction.corrected_y     = out_corr_q[CH_Y];
	assign correction.corrected_angle = out_corr_q[CH_ANG];
	assign correction.final_result    = out_final_q;

`ifndef NO_ASSERTIONS
	// fill count never passes the ring depth
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q <= RING_C)
		else $error("frame count beyond ring depth");

	// points are dropped from the window only while flushing
	a_trim_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TRIM_SUB |-> eos_q)
		else $error("window trimmed outside the final item");

	// divider is never restarted mid-division
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!div_stat.busy || div_stat.done))
		else $error("divider started while busy");

	// window always covers the centre point
	a_window_centre: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q > k_q)
		else $error("window count does not reach the centre point");
`endif

endmodule
